### rtl/assert_macros.svh
// Assertion macros shared by the RTL; compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TESL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define TESL_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define TESL_ASSERT(lbl, clk, rst, prop)

`define TESL_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

### rtl/tesl_pkg.sv
// Types and constants of the tab expander.
package tesl_pkg;

  localparam int COL_W     = 16;
  localparam int NUM_STOPS = 6;
  localparam int REM_W     = 6;   // remainder mod a tab width of at most 64
  localparam int CNT_W     = 3;

  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_NL    = 8'd10;
  localparam logic [7:0] BYTE_SPACE = 8'd32;

  localparam logic [COL_W-1:0] COL_MAX = '1;

  typedef enum logic [2:0] {
    REG_STOP_COUNT = 3'd0,
    REG_STOP_0     = 3'd1,
    REG_STOP_1     = 3'd2,
    REG_STOP_2     = 3'd3,
    REG_STOP_3     = 3'd4,
    REG_STOP_4     = 3'd5,
    REG_STOP_5     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                                busy;
    logic [CNT_W-1:0]                    in_use;
    logic [NUM_STOPS-1:0][COL_W-1:0]     stops;
    logic [NUM_STOPS-1:0][REM_W-1:0]     rems;   // each stop mod tab width
  } stop_cfg_t;

endpackage

### rtl/tab_expander_with_stop_list_unit.sv
// Top level of the tab expander with a configurable list of tab stops.
//
// Takes one text byte per beat and returns one beat per byte: the byte with a
// repeat count of one, or for a tab a space with the count that reaches the
// next stop. A byte is taken every cycle while no stop write is busy and the
// output is not stalled; its result passes the input register, then the result
// register. The column and its remainder modulo TAB_WIDTH are updated in the
// cycle a byte moves into the result register, so back-to-back tabs cost
// nothing extra. Writing a stop register starts a remainder computation of that
// stop modulo TAB_WIDTH by reciprocal multiplication; cfg_ready and in_ready
// stay low for a single cycle while it runs.
`include "assert_macros.svh"

module tab_expander_with_stop_list_unit
  import tesl_pkg::*;
#(
  parameter int TAB_WIDTH = 8,
  parameter int MAX_STOPS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [COL_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [COL_W-1:0] repeat_count
);

  stop_cfg_t cfg;

  tesl_cfg #(
    .TAB_WIDTH (TAB_WIDTH),
    .MAX_STOPS (MAX_STOPS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tesl_core #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .repeat_count (repeat_count)
  );

  `TESL_ASSERT_NEVER(a_busy_blocks_input, clk, rst, cfg.busy && in_ready)
  `TESL_ASSERT(a_count_nonzero, clk, rst, out_valid |-> (repeat_count != '0))
  `TESL_ASSERT(a_plain_count_one, clk, rst, (out_valid && out_byte != BYTE_SPACE) |-> (repeat_count == COL_W'(1)))
  `TESL_ASSERT(a_stop_write_busy, clk, rst, (cfg_valid && cfg_ready && cfg_index >= REG_STOP_0 && cfg_index <= REG_STOP_5) |=> cfg.busy)

endmodule

### rtl/tesl_cfg.sv
// Configuration registers and the remainder unit for the stop columns.
module tesl_cfg
  import tesl_pkg::*;
#(
  parameter int TAB_WIDTH = 8,
  parameter int MAX_STOPS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [COL_W-1:0] cfg_data,
  output stop_cfg_t        cfg
);

  // floor(x * RECIP / 2^SH) equals x / TAB_WIDTH for every 16-bit x
  localparam int SH     = COL_W + $clog2(TAB_WIDTH);
  localparam int PROD_W = SH + COL_W;
  localparam logic [COL_W:0] RECIP =
    (COL_W+1)'(((longint'(1) << SH) + longint'(TAB_WIDTH) - 1) / longint'(TAB_WIDTH));
  localparam logic [COL_W-1:0] TW = COL_W'(TAB_WIDTH);
  localparam logic [REM_W-1:0] RST_REM [NUM_STOPS] = '{
    REM_W'(8 % TAB_WIDTH),  REM_W'(16 % TAB_WIDTH), REM_W'(24 % TAB_WIDTH),
    REM_W'(32 % TAB_WIDTH), REM_W'(40 % TAB_WIDTH), REM_W'(48 % TAB_WIDTH)
  };

  logic [CNT_W-1:0]             stop_count;
  logic [NUM_STOPS-1:0][COL_W-1:0] stops;
  logic [NUM_STOPS-1:0][REM_W-1:0] rems;

  logic              div_busy;
  logic [COL_W-1:0]  div_val;
  logic [2:0]        div_idx;
  logic [PROD_W-1:0] div_prod;
  logic [COL_W-1:0]  div_quot;
  logic [COL_W-1:0]  div_diff;
  logic [REM_W-1:0]  div_rem;
  logic              cfg_fire;

  assign cfg_ready = !div_busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // remainder is below TAB_WIDTH, so the low bits of the difference are exact
  assign div_prod = PROD_W'(div_val) * PROD_W'(RECIP);
  assign div_quot = div_prod[PROD_W-1 -: COL_W];
  assign div_diff = div_val - COL_W'(div_quot * TW);
  assign div_rem  = div_diff[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= '0;
      div_busy   <= 1'b0;
      for (int i = 0; i < NUM_STOPS; i++) begin
        stops[i] <= COL_W'(8 * (i + 1));
        rems[i]  <= RST_REM[i];
      end
    end else begin
      if (cfg_fire) begin
        case (cfg_reg_t'(cfg_index))
          REG_STOP_COUNT: begin
            stop_count <= cfg_data[CNT_W-1:0];
          end
          REG_STOP_0, REG_STOP_1, REG_STOP_2,
          REG_STOP_3, REG_STOP_4, REG_STOP_5: begin
            for (int i = 0; i < NUM_STOPS; i++) begin
              if (cfg_index == 3'(i + 1)) stops[i] <= cfg_data;
            end
            div_busy <= 1'b1;
          end
          default: begin
          end
        endcase
      end else if (div_busy) begin
        div_busy <= 1'b0;
        for (int i = 0; i < NUM_STOPS; i++) begin
          if (div_idx == 3'(i)) rems[i] <= div_rem;
        end
      end
    end
  end

  // operand of the remainder unit
  always_ff @(posedge clk) begin
    if (cfg_fire) begin
      div_val <= cfg_data;
      div_idx <= cfg_index - 3'd1;
    end
  end

  always_comb begin
    cfg.busy   = div_busy;
    cfg.in_use = (stop_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count;
    cfg.stops  = stops;
    cfg.rems   = rems;
  end

endmodule

### rtl/tesl_core.sv
// Input register, column tracking and result register of the tab expander.
module tesl_core
  import tesl_pkg::*;
#(
  parameter int TAB_WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  stop_cfg_t        cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [COL_W-1:0] repeat_count
);

  localparam logic [REM_W:0]   TW      = (REM_W+1)'(TAB_WIDTH);
  localparam logic [REM_W-1:0] SAT_REM = REM_W'(65535 % TAB_WIDTH);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_adv;

  logic [COL_W-1:0] col;
  logic [REM_W-1:0] cmod;   // col mod tab width
  logic [COL_W-1:0] col_next;
  logic [REM_W-1:0] cmod_next;
  logic [7:0]       byte_next;
  logic [COL_W-1:0] rep_next;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !cfg.busy && (!s1_valid || s1_adv);

  always_comb begin
    logic             found;
    logic [COL_W-1:0] hit_stop;
    logic [REM_W-1:0] hit_rem;
    logic [COL_W-1:0] base;
    logic [REM_W-1:0] brem;
    logic [REM_W:0]   phase;
    logic [COL_W-1:0] rep;
    logic [REM_W-1:0] srem;
    logic [COL_W:0]   stop_sum;

    found    = 1'b0;
    hit_stop = '0;
    hit_rem  = '0;
    base     = '0;
    brem     = '0;
    for (int i = 0; i < NUM_STOPS; i++) begin
      if (!found && (CNT_W'(i) < cfg.in_use) && (cfg.stops[i] > col)) begin
        found    = 1'b1;
        hit_stop = cfg.stops[i];
        hit_rem  = cfg.rems[i];
      end
      if (cfg.in_use == CNT_W'(i + 1)) begin
        base = cfg.stops[i];
        brem = cfg.rems[i];
      end
    end

    // distance past the last stop, mod tab width
    phase = ({1'b0, cmod} >= {1'b0, brem}) ? {1'b0, cmod} - {1'b0, brem}
                                           : {1'b0, cmod} + TW - {1'b0, brem};
    if (found) begin
      rep  = hit_stop - col;
      srem = hit_rem;
    end else if (col < base) begin
      rep  = base - col;
      srem = brem;
    end else begin
      rep  = COL_W'(TW - phase);
      srem = brem;
    end
    stop_sum = {1'b0, col} + {1'b0, rep};

    byte_next = s1_byte;
    rep_next  = COL_W'(1);
    col_next  = col;
    cmod_next = cmod;
    if (s1_byte == BYTE_NL) begin
      col_next  = '0;
      cmod_next = '0;
    end else if (s1_byte == BYTE_TAB) begin
      byte_next = BYTE_SPACE;
      rep_next  = rep;
      if (stop_sum[COL_W]) begin
        col_next  = COL_MAX;
        cmod_next = SAT_REM;
      end else begin
        col_next  = stop_sum[COL_W-1:0];
        cmod_next = srem;
      end
    end else if (col != COL_MAX) begin
      col_next  = col + COL_W'(1);
      cmod_next = ({1'b0, cmod} == TW - 1'b1) ? '0 : cmod + REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      col       <= '0;
      cmod      <= '0;
    end else begin
      if (in_valid && in_ready) s1_valid <= 1'b1;
      else if (s1_adv)          s1_valid <= 1'b0;
      if (s1_adv) begin
        out_valid <= 1'b1;
        col       <= col_next;
        cmod      <= cmod_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= in_byte;
    if (s1_adv) begin
      out_byte     <= byte_next;
      repeat_count <= rep_next;
    end
  end

endmodule
